@@ design/gpe_pkg.sv @@
// shared types, constants and the base32 alphabet for the geohash point encoder
`default_nettype none
package gpe_pkg;

   localparam int MAX_CHARS_DEFAULT = 12;
   localparam int LAT_WIDTH = 40;
   localparam int LON_WIDTH = 41;
   localparam int COUNT_WIDTH = 4;
   localparam int SYMBOL_BITS = 5;
   localparam int CHAR_WIDTH = 7;

   // interval bounds in degrees times 2^32
   localparam logic signed [LAT_WIDTH-1:0] LAT_MAX = 40'sd386547056640;
   localparam logic signed [LAT_WIDTH-1:0] LAT_MIN = -40'sd386547056640;
   localparam logic signed [LON_WIDTH-1:0] LON_MAX = 41'sd773094113280;
   localparam logic signed [LON_WIDTH-1:0] LON_MIN = -41'sd773094113280;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POINT     = 2'd1,
      STATUS_PRECISION = 2'd2
   } rsp_status_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic emit_char;
      logic emit_err;
      logic last;
   } gpe_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                   point_bad;
      logic                   count_bad;
      logic [COUNT_WIDTH-1:0] num_chars;
   } gpe_stat_type;

   localparam logic [CHAR_WIDTH-1:0] ALPHABET [32] = '{
      7'd48,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,
      7'd56,  7'd57,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
      7'd104, 7'd106, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd114,
      7'd115, 7'd116, 7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122
   };

   function automatic logic [CHAR_WIDTH-1:0] base32_char(input logic [SYMBOL_BITS-1:0] sym);
      base32_char = ALPHABET[sym];
   endfunction

endpackage
`default_nettype wire

@@ design/geohash_point_encoder.sv @@
// top level of the geohash point encoder: controller plus datapath
`default_nettype none
// usage
//  - request channel: a transaction is taken at a rising edge with start high
//    and busy low; req_latitude and req_longitude are degrees times 2^32,
//    req_num_chars is the number of geohash characters wanted
//  - response channel: each character comes as one transaction, rsp_valid
//    high for exactly one cycle; rsp_last marks the final one of a point
//  - the receiver cannot hold responses off, and none is needed: results are
//    produced from a result register
//  - a point off the globe or a bad count gives one transaction with
//    rsp_last high, nonzero rsp_status and zero character and symbol
// timing
//  - one shared bisection unit resolves one bit per cycle, longitude first
//  - after a range-check state, the bisection unit builds each character from
//    five bit steps and puts it in the result register
//  - busy covers the range check and the bit steps of all N characters (only
//    the range check on an error), so a new transaction waits for the last
//  - the final result sits in its register while the next transaction starts
// reset
//  - synchronous reset returns the sequencer to idle and drops rsp_valid
module geohash_point_encoder #(
   parameter int MAX_CHARS = gpe_pkg::MAX_CHARS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [gpe_pkg::LAT_WIDTH-1:0]  req_latitude,
   input  wire logic signed [gpe_pkg::LON_WIDTH-1:0]  req_longitude,
   input  wire logic [gpe_pkg::COUNT_WIDTH-1:0]       req_num_chars,
   output logic                                       rsp_valid,
   output logic [gpe_pkg::CHAR_WIDTH-1:0]             rsp_hash_char,
   output logic [gpe_pkg::SYMBOL_BITS-1:0]            rsp_symbol,
   output logic                                       rsp_last,
   output logic [1:0]                                 rsp_status
);

   // command and status between sequencer and datapath
   gpe_pkg::gpe_cmd_type  cmd;
   gpe_pkg::gpe_stat_type stat;

   // sequencer: idle, range check, then five bit steps per character
   gpe_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // operands, interval bounds, bisection and result registers
   gpe_datapath #(
      .MAX_CHARS (MAX_CHARS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_latitude   (req_latitude),
      .req_longitude  (req_longitude),
      .req_num_chars  (req_num_chars),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_hash_char  (rsp_hash_char),
      .rsp_symbol     (rsp_symbol),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

endmodule
`default_nettype wire

@@ design/gpe_controller.sv @@
// sequencer for the geohash encoder: range check, bit steps and character strobes
`default_nettype none
module gpe_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire gpe_pkg::gpe_stat_type stat,
   output gpe_pkg::gpe_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CHECK = 3'b010,
      ST_STEP  = 3'b100
   } state_type;

   localparam logic [2:0] LastBit = 3'(gpe_pkg::SYMBOL_BITS - 1);

   state_type state_ff, state_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;
   logic [gpe_pkg::COUNT_WIDTH-1:0] char_cnt_ff, char_cnt_in;
   logic final_char;

   assign final_char = ({1'b0, char_cnt_ff} + 5'd1) == {1'b0, stat.num_chars};

   always_comb begin
      state_in    = state_ff;
      bit_cnt_in  = bit_cnt_ff;
      char_cnt_in = char_cnt_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            bit_cnt_in  = '0;
            char_cnt_in = '0;
            if (stat.point_bad || stat.count_bad) begin
               cmd.emit_err = 1'b1;
               cmd.last     = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (bit_cnt_ff == LastBit) begin
               cmd.emit_char = 1'b1;
               cmd.last      = final_char;
               bit_cnt_in    = '0;
               char_cnt_in   = char_cnt_ff + 4'd1;
               if (final_char) begin
                  state_in = ST_IDLE;
               end
            end else begin
               bit_cnt_in = bit_cnt_ff + 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         bit_cnt_ff  <= '0;
         char_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         bit_cnt_ff  <= bit_cnt_in;
         char_cnt_ff <= char_cnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

@@ design/gpe_datapath.sv @@
// operand registers, shared bisection unit, symbol shifter and result registers
`default_nettype none
module gpe_datapath #(
   parameter int MAX_CHARS = gpe_pkg::MAX_CHARS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic signed [gpe_pkg::LAT_WIDTH-1:0]   req_latitude,
   input  wire logic signed [gpe_pkg::LON_WIDTH-1:0]   req_longitude,
   input  wire logic [gpe_pkg::COUNT_WIDTH-1:0]        req_num_chars,
   input  wire gpe_pkg::gpe_cmd_type                   cmd,
   output gpe_pkg::gpe_stat_type                       stat,
   output logic                                        rsp_valid,
   output logic [gpe_pkg::CHAR_WIDTH-1:0]              rsp_hash_char,
   output logic [gpe_pkg::SYMBOL_BITS-1:0]             rsp_symbol,
   output logic                                        rsp_last,
   output logic [1:0]                                  rsp_status
);

   localparam int LatW = gpe_pkg::LAT_WIDTH;
   localparam int LonW = gpe_pkg::LON_WIDTH;
   localparam int SymW = gpe_pkg::SYMBOL_BITS;
   localparam logic [gpe_pkg::COUNT_WIDTH-1:0] MaxCount = gpe_pkg::COUNT_WIDTH'(MAX_CHARS);

   logic signed [LatW-1:0] lat_ff, lat_lo_ff, lat_hi_ff;
   logic signed [LonW-1:0] lon_ff, lon_lo_ff, lon_hi_ff;
   logic [gpe_pkg::COUNT_WIDTH-1:0] count_ff;
   logic on_lon_ff;
   logic [SymW-1:0] sym_ff, sym_in;

   logic signed [LonW-1:0] sel_val, sel_lo, sel_hi, mid;
   logic signed [LonW:0] mid_sum;
   logic bit_out;

   logic valid_ff;
   logic [gpe_pkg::CHAR_WIDTH-1:0] char_ff;
   logic [SymW-1:0] symbol_ff;
   logic last_ff;
   logic [1:0] status_ff;

   // status toward the controller
   assign stat.point_bad = (lat_ff < gpe_pkg::LAT_MIN) || (lat_ff > gpe_pkg::LAT_MAX) ||
                           (lon_ff < gpe_pkg::LON_MIN) || (lon_ff > gpe_pkg::LON_MAX);
   assign stat.count_bad = (count_ff == '0) || (count_ff > MaxCount);
   assign stat.num_chars = count_ff;

   // one bisection per step; lat widened to the lon width, sum is always even
   always_comb begin
      if (on_lon_ff) begin
         sel_val = lon_ff;
         sel_lo  = lon_lo_ff;
         sel_hi  = lon_hi_ff;
      end else begin
         sel_val = LonW'(lat_ff);
         sel_lo  = LonW'(lat_lo_ff);
         sel_hi  = LonW'(lat_hi_ff);
      end
      mid_sum = {sel_lo[LonW-1], sel_lo} + {sel_hi[LonW-1], sel_hi};
      mid     = mid_sum[LonW:1];
      bit_out = (sel_val >= mid);
      sym_in  = {sym_ff[SymW-2:0], bit_out};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lat_ff    <= req_latitude;
         lon_ff    <= req_longitude;
         count_ff  <= req_num_chars;
         lat_lo_ff <= gpe_pkg::LAT_MIN;
         lat_hi_ff <= gpe_pkg::LAT_MAX;
         lon_lo_ff <= gpe_pkg::LON_MIN;
         lon_hi_ff <= gpe_pkg::LON_MAX;
         on_lon_ff <= 1'b1;
         sym_ff    <= '0;
      end else if (cmd.step) begin
         on_lon_ff <= !on_lon_ff;
         sym_ff    <= sym_in;
         if (on_lon_ff) begin
            if (bit_out) begin
               lon_lo_ff <= mid;
            end else begin
               lon_hi_ff <= mid;
            end
         end else begin
            if (bit_out) begin
               lat_lo_ff <= mid[LatW-1:0];
            end else begin
               lat_hi_ff <= mid[LatW-1:0];
            end
         end
      end
   end

   // result registers, strobe for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit_char || cmd.emit_err;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_err) begin
         char_ff   <= '0;
         symbol_ff <= '0;
         last_ff   <= 1'b1;
         status_ff <= stat.point_bad ? gpe_pkg::STATUS_POINT : gpe_pkg::STATUS_PRECISION;
      end else if (cmd.emit_char) begin
         char_ff   <= gpe_pkg::base32_char(sym_in);
         symbol_ff <= sym_in;
         last_ff   <= cmd.last;
         status_ff <= gpe_pkg::STATUS_OK;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_hash_char = char_ff;
   assign rsp_symbol    = symbol_ff;
   assign rsp_last      = last_ff;
   assign rsp_status    = status_ff;

endmodule
`default_nettype wire

@@ design/gpe_checker.sv @@
// port-level assertions for the geohash point encoder and their bind
`default_nettype none
module gpe_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  start,
   input wire logic                                  busy,
   input wire logic                                  rsp_valid,
   input wire logic [gpe_pkg::CHAR_WIDTH-1:0]        rsp_hash_char,
   input wire logic [gpe_pkg::SYMBOL_BITS-1:0]       rsp_symbol,
   input wire logic                                  rsp_last,
   input wire logic [1:0]                            rsp_status
);

   // a taken transaction keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted transaction");

   // an error response is a single, empty, final transaction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != gpe_pkg::STATUS_OK) |->
         (rsp_last && rsp_hash_char == '0 && rsp_symbol == '0))
      else $error("error response not final or not zero");

   // a good character is never the zero code (alphabet codes are printable)
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == gpe_pkg::STATUS_OK) |-> (rsp_hash_char != '0))
      else $error("ok response without a character");

   // reset leaves the block idle with no response
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("block not idle after reset");

endmodule

bind geohash_point_encoder gpe_checker u_gpe_checker (.*);
`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the geohash point encoder
`default_nettype none
module testbench;

   // one geohash character as it should appear on the response channel
   typedef struct {
      logic [gpe_pkg::CHAR_WIDTH-1:0]  hash_char;
      logic [gpe_pkg::SYMBOL_BITS-1:0] symbol;
      logic                            last;
      gpe_pkg::rsp_status_type         status;
   } geohash_char_type;

   // degrees times 2^32, held in 64 bits like the bisection bounds
   localparam longint ONE_DEGREE = longint'(1) <<< 32;
   localparam longint LAT_LIMIT = 90 * ONE_DEGREE;
   localparam longint LON_LIMIT = 180 * ONE_DEGREE;
   localparam int QUIET_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [gpe_pkg::LAT_WIDTH-1:0] req_latitude = '0;
   logic signed [gpe_pkg::LON_WIDTH-1:0] req_longitude = '0;
   logic [gpe_pkg::COUNT_WIDTH-1:0] req_num_chars = '0;
   logic rsp_valid;
   logic [gpe_pkg::CHAR_WIDTH-1:0] rsp_hash_char;
   logic [gpe_pkg::SYMBOL_BITS-1:0] rsp_symbol;
   logic rsp_last;
   logic [1:0] rsp_status;

   geohash_char_type pending_chars[$];
   string geohash_alphabet = "0123456789bcdefghjkmnpqrstuvwxyz";
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int sender_idle_pct = 0;

   always #10 clock = ~clock;

   geohash_point_encoder u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_latitude  (req_latitude),
      .req_longitude (req_longitude),
      .req_num_chars (req_num_chars),
      .rsp_valid     (rsp_valid),
      .rsp_hash_char (rsp_hash_char),
      .rsp_symbol    (rsp_symbol),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status)
   );

   // only the first few failures are printed, the rest are counted
   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // expected characters of one point: range check, count check, then
   // alternating bisection of longitude and latitude, five bits a symbol
   function automatic void predict_geohash(input logic signed [gpe_pkg::LAT_WIDTH-1:0] lat,
                                           input logic signed [gpe_pkg::LON_WIDTH-1:0] lon,
                                           input logic [gpe_pkg::COUNT_WIDTH-1:0] count);
      longint lat_v, lon_v, lat_lo, lat_hi, lon_lo, lon_hi, mid;
      logic [gpe_pkg::SYMBOL_BITS-1:0] sym;
      logic on_lon;
      geohash_char_type ch;
      lat_v = longint'(lat);
      lon_v = longint'(lon);
      lat_lo = -LAT_LIMIT;
      lat_hi = LAT_LIMIT;
      lon_lo = -LON_LIMIT;
      lon_hi = LON_LIMIT;
      on_lon = 1'b1;
      ch.hash_char = '0;
      ch.symbol = '0;
      ch.last = 1'b1;
      // an off-globe point wins over a bad count
      if (lat_v < lat_lo || lat_v > lat_hi || lon_v < lon_lo || lon_v > lon_hi) begin
         ch.status = gpe_pkg::STATUS_POINT;
         pending_chars.push_back(ch);
      end else if (count == 0 || count > gpe_pkg::MAX_CHARS_DEFAULT) begin
         ch.status = gpe_pkg::STATUS_PRECISION;
         pending_chars.push_back(ch);
      end else begin
         for (int c = 0; c < count; c++) begin
            sym = '0;
            for (int b = 0; b < gpe_pkg::SYMBOL_BITS; b++) begin
               if (on_lon) begin
                  mid = lon_lo + (lon_hi - lon_lo) / 2;
                  // at or above the midpoint takes the upper half
                  if (lon_v >= mid) begin
                     lon_lo = mid;
                     sym = {sym[gpe_pkg::SYMBOL_BITS-2:0], 1'b1};
                  end else begin
                     lon_hi = mid;
                     sym = {sym[gpe_pkg::SYMBOL_BITS-2:0], 1'b0};
                  end
               end else begin
                  mid = lat_lo + (lat_hi - lat_lo) / 2;
                  if (lat_v >= mid) begin
                     lat_lo = mid;
                     sym = {sym[gpe_pkg::SYMBOL_BITS-2:0], 1'b1};
                  end else begin
                     lat_hi = mid;
                     sym = {sym[gpe_pkg::SYMBOL_BITS-2:0], 1'b0};
                  end
               end
               on_lon = ~on_lon;
            end
            ch.symbol = sym;
            ch.hash_char = gpe_pkg::CHAR_WIDTH'(geohash_alphabet[sym]);
            ch.last = (c + 1 == count);
            ch.status = gpe_pkg::STATUS_OK;
            pending_chars.push_back(ch);
         end
      end
   endfunction

   // one transaction on the request channel; called just after a rising edge.
   // start stays high on return so back-to-back points need no extra step
   task automatic send_point(input longint lat, input longint lon, input int count);
      logic signed [gpe_pkg::LAT_WIDTH-1:0] lat_bits;
      logic signed [gpe_pkg::LON_WIDTH-1:0] lon_bits;
      logic [gpe_pkg::COUNT_WIDTH-1:0] count_bits;
      // values wider than the ports keep only their low bits
      lat_bits = gpe_pkg::LAT_WIDTH'(lat);
      lon_bits = gpe_pkg::LON_WIDTH'(lon);
      count_bits = gpe_pkg::COUNT_WIDTH'(count);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_latitude <= lat_bits;
      req_longitude <= lon_bits;
      req_num_chars <= count_bits;
      // the edge that sees busy low with start high takes the transaction
      do @(posedge clock); while (busy !== 1'b0);
      predict_geohash(lat_bits, lon_bits, count_bits);
   endtask

   // hold off the sender until every expected character has come out
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // uniform value in [-limit, limit]
   function automatic longint random_coord(input longint limit);
      longint unsigned r;
      r = {$urandom, $urandom};
      return longint'(r % longint'(2 * limit + 1)) - limit;
   endfunction

   // a point on a bisection grid, so the coordinate often equals a midpoint
   function automatic longint grid_coord(input longint limit);
      int depth;
      longint step;
      depth = $urandom_range(1, 24);
      step = (2 * limit) >>> depth;
      return -limit + step * longint'($urandom_range(0, (1 << depth)));
   endfunction

   // mostly short hashes, sometimes up to the full length
   function automatic int random_count();
      if ($urandom_range(99) < 60) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(1, gpe_pkg::MAX_CHARS_DEFAULT);
   endfunction

   // corners of the globe, the equator and prime meridian, exact midpoints
   task automatic test_valid_corners();
      send_point('0, '0, 1);
      send_point(LAT_LIMIT, LON_LIMIT, 12);
      send_point(-LAT_LIMIT, -LON_LIMIT, 12);
      send_point(LAT_LIMIT, -LON_LIMIT, 7);
      send_point(-LAT_LIMIT, LON_LIMIT, 5);
      send_point(45 * ONE_DEGREE, -90 * ONE_DEGREE, 12);
      send_point(-1, -1, 12);
      send_point(1, 1, 12);
      send_point(LAT_LIMIT - 1, LON_LIMIT - 1, 12);
   endtask

   // points just past the bounds and at the extremes of the port widths
   task automatic test_point_errors();
      send_point(LAT_LIMIT + 1, '0, 3);
      send_point(-LAT_LIMIT - 1, '0, 3);
      send_point('0, LON_LIMIT + 1, 3);
      send_point('0, -LON_LIMIT - 1, 3);
      send_point({1'b0, {(gpe_pkg::LAT_WIDTH-1){1'b1}}}, '0, 12);
      send_point({1'b1, {(gpe_pkg::LAT_WIDTH-1){1'b0}}}, '0, 12);
      send_point('0, {1'b0, {(gpe_pkg::LON_WIDTH-1){1'b1}}}, 12);
      send_point('0, {1'b1, {(gpe_pkg::LON_WIDTH-1){1'b0}}}, 12);
      // off-globe point and bad count together: the point error wins
      send_point(LAT_LIMIT + 1, '0, 0);
      send_point('1, LON_LIMIT + 1, 15);
   endtask

   // counts of zero and above the maximum on a good point
   task automatic test_precision_errors();
      send_point(10 * ONE_DEGREE, 20 * ONE_DEGREE, 0);
      send_point(10 * ONE_DEGREE, 20 * ONE_DEGREE, 13);
      send_point(-10 * ONE_DEGREE, -20 * ONE_DEGREE, 15);
   endtask

   task automatic test_random_points(input int items, input int idle_pct);
      int kind;
      longint lat;
      longint lon;
      sender_idle_pct = idle_pct;
      for (int i = 0; i < items; i++) begin
         kind = $urandom_range(99);
         if (kind < 65) begin
            send_point(random_coord(LAT_LIMIT), random_coord(LON_LIMIT), random_count());
         end else if (kind < 80) begin
            send_point(grid_coord(LAT_LIMIT), grid_coord(LON_LIMIT), random_count());
         end else if (kind < 90) begin
            // raw noise over the full port widths, any count
            lat = {$urandom, $urandom};
            lon = {$urandom, $urandom};
            send_point(lat, lon, $urandom_range(0, 15));
         end else begin
            send_point(random_coord(LAT_LIMIT), random_coord(LON_LIMIT),
                       ($urandom_range(1) != 0) ? 0 : int'($urandom_range(13, 15)));
         end
      end
      sender_idle_pct = 0;
   endtask

   // response checker: every strobed transaction against the oldest expectation
   always @(posedge clock) begin : check_rsp
      geohash_char_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_chars.size() == 0) begin
            note_mismatch($sformatf("unexpected response char %0d sym %0d last %0b status %0d",
                                    rsp_hash_char, rsp_symbol, rsp_last, rsp_status));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_hash_char !== want.hash_char || rsp_symbol !== want.symbol ||
                rsp_last !== want.last || rsp_status !== want.status) begin
               note_mismatch($sformatf({"response mismatch: expected char %0d sym %0d last %0b",
                                        " status %0d, got char %0d sym %0d last %0b status %0d"},
                                       want.hash_char, want.symbol, want.last, want.status,
                                       rsp_hash_char, rsp_symbol, rsp_last, rsp_status));
            end
         end
      end
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_valid_corners();
      test_point_errors();
      test_precision_errors();
      wait_drained();
      // sender idles rarely, then often, then never
      test_random_points(30, 13);
      wait_drained();
      test_random_points(30, 52);
      wait_drained();
      test_random_points(30, 0);
      wait_drained();
      if (pending_chars.size() != 0) begin
         note_mismatch($sformatf("%0d expected responses never arrived", pending_chars.size()));
      end
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
design/gpe_pkg.sv
design/gpe_controller.sv
design/gpe_datapath.sv
design/geohash_point_encoder.sv
design/gpe_checker.sv
tb/testbench.sv
